@@ hw/rtl/trd_pkg.sv @@
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the temporal recursive denoiser.
// ----------------------------------------------------------------------------
package trd_pkg;

  // Frame store geometry
  localparam int FRAME_PIXELS = 65536;
  localparam int POS_W        = $clog2(FRAME_PIXELS + 1);
  localparam int ADDR_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  // Pixel format
  localparam int NUM_COMP = 4;
  localparam int COMP_W   = 16;
  localparam int WORD_W   = NUM_COMP * COMP_W;

  // Pipeline stages between the store read and the write back
  localparam int NSTG = 4;

  // Blend weight arithmetic
  localparam int ONE_FIXED     = 65536;
  localparam int MAX_FRAMES    = 256;
  localparam int FRAMES_W      = 9;
  localparam int FRAMES_RESET  = 2;
  localparam int WEIGHT_W      = 17;
  localparam int WEIGHT_RESET  = ONE_FIXED / FRAMES_RESET;
  localparam int DIV_CNT_W     = $clog2(WEIGHT_W + 1);

  // Configuration registers
  localparam int THR_W        = 16;
  localparam int THR_RESET    = 6553;
  localparam int MASK_RESET   = 15;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES    = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_ENABLE    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic              start_of_frame;
    logic              history_cleared;
    logic [COMP_W-1:0] comp_zero;
    logic [COMP_W-1:0] comp_one;
    logic [COMP_W-1:0] comp_two;
    logic [COMP_W-1:0] comp_three;
  } trd_in_t;

  typedef struct packed {
    logic [COMP_W-1:0]   out_zero;
    logic [COMP_W-1:0]   out_one;
    logic [COMP_W-1:0]   out_two;
    logic [COMP_W-1:0]   out_three;
    logic [NUM_COMP-1:0] reload_mask;
    logic                position_overflow;
  } trd_out_t;

  // What one component lane hands back at the last stage
  typedef struct packed {
    logic [COMP_W-1:0] result;
    logic [COMP_W-1:0] acc_new;
    logic              reload;
  } trd_lane_res_t;

endpackage

@@ hw/rtl/trd_ram.sv @@
// ----------------------------------------------------------------------------
// trd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/trd_wdiv.sv @@
// ----------------------------------------------------------------------------
// trd_wdiv
// Blend weight register: restoring divide of 65536 by the averaging length,
// one quotient bit per cycle after each write of the length.
// ----------------------------------------------------------------------------
module trd_wdiv import trd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [FRAMES_W-1:0] frames,
  output logic                busy,
  output logic [WEIGHT_W-1:0] weight
);

  logic                busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [FRAMES_W-1:0] div_r;
  logic [FRAMES_W-1:0] rem_r;
  logic [WEIGHT_W-1:0] quo_r;
  logic [WEIGHT_W-1:0] weight_r;

  logic [FRAMES_W-1:0] div_eff;
  logic [FRAMES_W:0]   rem_sh;
  logic                ge;
  logic [FRAMES_W-1:0] rem_nxt;
  logic [WEIGHT_W-1:0] quo_nxt;

  // Out-of-range length acts as the maximum
  always_comb begin
    if (frames == '0 || frames > FRAMES_W'(MAX_FRAMES)) begin
      div_eff = FRAMES_W'(MAX_FRAMES);
    end else begin
      div_eff = frames;
    end
  end

  always_comb begin
    rem_sh  = {rem_r, quo_r[WEIGHT_W-1]};
    ge      = rem_sh >= {1'b0, div_r};
    rem_nxt = ge ? FRAMES_W'(rem_sh - {1'b0, div_r}) : rem_sh[FRAMES_W-1:0];
    quo_nxt = {quo_r[WEIGHT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      weight_r <= WEIGHT_W'(WEIGHT_RESET);
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(WEIGHT_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r   <= 1'b0;
        weight_r <= quo_nxt;
      end
    end
  end

  // Datapath of the divider
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= div_eff;
      rem_r <= '0;
      quo_r <= WEIGHT_W'(ONE_FIXED);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy   = busy_r;
  assign weight = weight_r;

endmodule

@@ hw/rtl/trd_lane.sv @@
// ----------------------------------------------------------------------------
// trd_lane
// One component's blend datapath: difference, weight multiply, accumulate,
// threshold compare, over stages one to four of the pipeline.
// ----------------------------------------------------------------------------
module trd_lane import trd_pkg::*; (
  input  logic                clk,
  input  logic                adv,
  input  logic                s1_en,
  input  logic                s1_clear,
  input  logic [COMP_W-1:0]   s1_sample,
  input  logic [COMP_W-1:0]   rd_acc,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [THR_W-1:0]    threshold,
  output trd_lane_res_t       res
);

  // Stage 1: difference against the stored accumulator
  logic [COMP_W-1:0]   acc1;
  logic signed [COMP_W:0] d1;

  // Stage 2 registers and product
  logic                   en2_r;
  logic [COMP_W-1:0]      acc2_r;
  logic [COMP_W-1:0]      samp2_r;
  logic signed [COMP_W:0] d2_r;
  logic signed [WEIGHT_W+COMP_W:0] prod2;

  // Stage 3 registers and sum
  logic                     en3_r;
  logic [COMP_W-1:0]        acc3_r;
  logic [COMP_W-1:0]        samp3_r;
  logic signed [COMP_W+1:0] step3_r;
  logic signed [COMP_W+1:0] sum3;

  // Stage 4 registers and compare
  logic              en4_r;
  logic [COMP_W-1:0] acc4_r;
  logic [COMP_W-1:0] samp4_r;
  logic [COMP_W-1:0] blend4_r;
  logic [COMP_W-1:0] diff4;
  logic              over4;

  always_comb begin
    acc1 = s1_clear ? '0 : rd_acc;
    d1   = $signed({1'b0, s1_sample}) - $signed({1'b0, acc1});
  end

  // acc' = acc + floor(W * (in - acc) / 65536)
  assign prod2 = $signed({1'b0, weight}) * d2_r;
  assign sum3  = $signed({2'b00, acc3_r}) + step3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      en2_r    <= s1_en;
      acc2_r   <= acc1;
      samp2_r  <= s1_sample;
      d2_r     <= d1;
      en3_r    <= en2_r;
      acc3_r   <= acc2_r;
      samp3_r  <= samp2_r;
      step3_r  <= prod2[COMP_W+COMP_W+1:COMP_W];
      en4_r    <= en3_r;
      acc4_r   <= acc3_r;
      samp4_r  <= samp3_r;
      blend4_r <= sum3[COMP_W-1:0];
    end
  end

  always_comb begin
    diff4 = (blend4_r > samp4_r) ? (blend4_r - samp4_r) : (samp4_r - blend4_r);
    over4 = diff4 > threshold;
    res.reload = en4_r & over4;
    if (!en4_r) begin
      res.result  = samp4_r;
      res.acc_new = acc4_r;
    end else if (over4) begin
      res.result  = samp4_r;
      res.acc_new = samp4_r;
    end else begin
      res.result  = blend4_r;
      res.acc_new = blend4_r;
    end
  end

endmodule

@@ hw/rtl/temporal_recursive_denoise.sv @@
// ----------------------------------------------------------------------------
// temporal_recursive_denoise
// Per-pixel recursive temporal filter with a motion threshold and a
// per-pixel accumulator frame store.
// ----------------------------------------------------------------------------
// out_valid rises as an accepted item moves from stage 4 to the output register.
// Throughput: one item per cycle while the output is not stalled. The input
//   also stalls while an item for the same store address is in the four stages
//   (frames of under five pixels) and during the divide after a REG_FRAMES write.
// Reset: synchronous, active low; clears control, position and the store
//   high-water mark, so the whole store reads as zero with no clearing pass.
module temporal_recursive_denoise import trd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  trd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output trd_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration
  logic [THR_W-1:0]    thr_r;
  logic [NUM_COMP-1:0] en_mask_r;
  logic                div_start;
  logic                div_busy;
  logic [WEIGHT_W-1:0] weight;

  // Position tracking; fill_r marks how far the store has been written since
  // reset. Positions are visited upward from zero, so every address below it
  // holds a written word and every address at or above it still reads as zero.
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] fill_r;
  logic [POS_W-1:0] cur_pos;
  logic             in_ovf;
  logic [ADDR_W-1:0] in_addr;
  logic             in_clear;

  // Handshake
  logic adv;
  logic hazard;
  logic accept;

  // Pipeline control, index 0 is stage 1 (read data back), 3 is stage 4
  logic              vld_r  [NSTG];
  logic              ovf_r  [NSTG];
  logic [ADDR_W-1:0] addr_r [NSTG];
  logic              clear1_r;
  logic [COMP_W-1:0] samp1_r [NUM_COMP];

  logic [COMP_W-1:0] in_samp [NUM_COMP];

  // Store
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  trd_lane_res_t     res [NUM_COMP];

  logic              out_valid_r;
  trd_out_t          out_data_r;

  // ---------------------------------------------------------------- config
  assign div_start = cfg_we && (cfg_index == REG_FRAMES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THR_W'(THR_RESET);
      en_mask_r <= NUM_COMP'(MASK_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r     <= cfg_wdata[THR_W-1:0];
        REG_ENABLE:    en_mask_r <= cfg_wdata[NUM_COMP-1:0];
        default:       ;  // length goes to the divider, unknown index drops
      endcase
    end
  end

  trd_wdiv u_wdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .frames (cfg_wdata[FRAMES_W-1:0]),
    .busy   (div_busy),
    .weight (weight)
  );

  // ---------------------------------------------------------------- input
  assign in_samp[0] = in_data.comp_zero;
  assign in_samp[1] = in_data.comp_one;
  assign in_samp[2] = in_data.comp_two;
  assign in_samp[3] = in_data.comp_three;

  always_comb begin
    cur_pos  = in_data.start_of_frame ? '0 : pos_r;
    in_ovf   = cur_pos >= POS_W'(FRAME_PIXELS);
    in_addr  = cur_pos[ADDR_W-1:0];
    in_clear = in_data.history_cleared || (cur_pos >= fill_r);
  end

  // Hold the input while an earlier item for this address has not written back
  always_comb begin
    hazard = 1'b0;
    for (int s = 0; s < NSTG; s++) begin
      if (vld_r[s] && !ovf_r[s] && !in_ovf && (addr_r[s] == in_addr)) begin
        hazard = 1'b1;
      end
    end
  end

  // Whole pipeline advances together whenever the output register can move
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || div_busy || hazard;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
    end else if (accept) begin
      // advance and saturate at the end of the store
      pos_r <= in_ovf ? cur_pos : cur_pos + 1'b1;
      if (!in_ovf && (cur_pos >= fill_r)) begin
        fill_r <= cur_pos + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= accept;
      for (int s = 1; s < NSTG; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ovf_r[0]  <= in_ovf;
      addr_r[0] <= in_addr;
      clear1_r  <= in_clear;
      for (int c = 0; c < NUM_COMP; c++) begin
        samp1_r[c] <= in_samp[c];
      end
      for (int s = 1; s < NSTG; s++) begin
        ovf_r[s]  <= ovf_r[s-1];
        addr_r[s] <= addr_r[s-1];
      end
    end
  end

  // Read at accept, write back when the item leaves stage 4
  assign ram_we = adv && vld_r[NSTG-1] && !ovf_r[NSTG-1];

  trd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FRAME_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r[NSTG-1]),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
    trd_lane u_lane (
      .clk       (clk),
      .adv       (adv),
      .s1_en     (en_mask_r[c] && !ovf_r[0]),
      .s1_clear  (clear1_r),
      .s1_sample (samp1_r[c]),
      .rd_acc    (ram_rdata[c*COMP_W +: COMP_W]),
      .weight    (weight),
      .threshold (thr_r),
      .res       (res[c])
    );
    assign ram_wdata[c*COMP_W +: COMP_W] = res[c].acc_new;
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.out_zero          <= res[0].result;
      out_data_r.out_one           <= res[1].result;
      out_data_r.out_two           <= res[2].result;
      out_data_r.out_three         <= res[3].result;
      out_data_r.reload_mask       <= {res[3].reload, res[2].reload,
                                       res[1].reload, res[0].reload};
      out_data_r.position_overflow <= ovf_r[NSTG-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the temporal recursive denoiser. A shadow of the
// frame store, the position counter and the three registers predicts every
// result item; the monitor compares each one field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import trd_pkg::*;

  // Pipeline depth from input acceptance to out_valid
  localparam int PIPE_LATENCY   = 4;
  // Quiet cycles allowed before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // Stop printing mismatch details after this many
  localparam int REPORT_LIMIT   = 100;
  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Generator keeps a slowly moving scene over this many positions
  localparam int SCENE_SLOTS    = 256;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  trd_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  trd_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAMES;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  temporal_recursive_denoise dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Pixels waiting to be driven, and filtered pixels waiting to come out
  trd_in_t  pending_pixels[$];
  trd_out_t predicted_pixels[$];

  // Shadow of the block: registers, frame store and position counter
  logic [FRAMES_W-1:0] avg_frames;
  logic [THR_W-1:0]    motion_thr;
  logic [NUM_COMP-1:0] lane_enable;
  logic [WORD_W-1:0]   acc_mem [FRAME_PIXELS];
  int                  pixel_pos;

  // Generator state: a per-slot scene that the samples hover around
  logic [COMP_W-1:0] scene [SCENE_SLOTS][NUM_COMP];
  int                gen_pos;

  // Traffic shaping knobs, set per phase by the stimulus
  int gap_max;
  int stall_max;
  int burst_left;
  int gap_left;
  int stall_left;

  int       mismatch_count;
  int       quiet_cycles;
  trd_out_t want;

  // --------------------------------------------------------------------------
  // Predictor: blend each enabled lane into its accumulator, reload on motion
  // --------------------------------------------------------------------------
  function automatic trd_out_t filter_pixel(trd_in_t px);
    trd_out_t            res;
    logic [COMP_W-1:0]   samp [NUM_COMP];
    logic [COMP_W-1:0]   lane_out [NUM_COMP];
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   next_word;
    logic [COMP_W-1:0]   acc;
    logic [COMP_W-1:0]   blended;
    logic [COMP_W-1:0]   diff;
    logic [NUM_COMP-1:0] reloaded;
    longint unsigned     wt;
    longint unsigned     mix;
    int                  f;
    int                  c;
    samp = '{px.comp_zero, px.comp_one, px.comp_two, px.comp_three};
    // Start of frame rewinds the position before this pixel is placed
    if (px.start_of_frame) pixel_pos = 0;
    if (pixel_pos >= FRAME_PIXELS) begin
      // Beyond the store: pass through, flag it, leave the store alone
      res.out_zero          = px.comp_zero;
      res.out_one           = px.comp_one;
      res.out_two           = px.comp_two;
      res.out_three         = px.comp_three;
      res.reload_mask       = '0;
      res.position_overflow = 1'b1;
      return res;
    end
    word = px.history_cleared ? '0 : acc_mem[pixel_pos];
    // Out-of-range averaging length acts as the longest one
    f = int'(avg_frames);
    if (f == 0 || f > MAX_FRAMES) f = MAX_FRAMES;
    wt = ONE_FIXED / f;
    next_word = '0;
    reloaded  = '0;
    for (c = 0; c < NUM_COMP; c++) begin
      acc = word[COMP_W*c +: COMP_W];
      lane_out[c] = samp[c];
      if (lane_enable[c]) begin
        mix = (ONE_FIXED - wt) * acc + wt * samp[c];
        blended = COMP_W'(mix >> 16);
        diff = (blended > samp[c]) ? blended - samp[c] : samp[c] - blended;
        if (diff > motion_thr) begin
          acc = samp[c];
          reloaded[c] = 1'b1;
        end else begin
          acc = blended;
          lane_out[c] = blended;
        end
      end
      // Disabled lanes write back what was read (zero under cleared history)
      next_word[COMP_W*c +: COMP_W] = acc;
    end
    acc_mem[pixel_pos] = next_word;
    pixel_pos++;
    res.out_zero          = lane_out[0];
    res.out_one           = lane_out[1];
    res.out_two           = lane_out[2];
    res.out_three         = lane_out[3];
    res.reload_mask       = reloaded;
    res.position_overflow = 1'b0;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: pop pending pixels in bursts, predict each one as it is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) predicted_pixels.push_back(filter_pixel(in_data));
      // Hold the payload while stalled; otherwise the slot is free
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_pixels.size() != 0) begin
          in_data  <= pending_pixels.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            // End of burst: pick the next burst and a gap, possibly none
            burst_left <= $urandom_range(48, 1);
            gap_left   <= (gap_max == 0) ? 0 : $urandom_range(gap_max);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: alternate open runs and stall runs of random length
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!out_stall && stall_max != 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(stall_max - 1);
    end else begin
      out_stall  <= 1'b0;
      // Now and then a long open stretch
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(30);
    end
  end

  task automatic check_field(string field, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $error("%s mismatch: expected %0h, got %0h", field, exp_val, act_val);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted result item with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (predicted_pixels.size() == 0) begin
        mismatch_count++;
        $error("result item with no pixel outstanding: %h", out_data);
      end else begin
        want = predicted_pixels.pop_front();
        check_field("out_zero", want.out_zero, out_data.out_zero);
        check_field("out_one", want.out_one, out_data.out_one);
        check_field("out_two", want.out_two, out_data.out_two);
        check_field("out_three", want.out_three, out_data.out_three);
        check_field("reload_mask", want.reload_mask, out_data.reload_mask);
        check_field("position_overflow", want.position_overflow,
                    out_data.position_overflow);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic trd_in_t px(bit sof, bit clr, logic [15:0] a, logic [15:0] b,
                                 logic [15:0] c, logic [15:0] d);
    trd_in_t p;
    p.start_of_frame  = sof;
    p.history_cleared = clr;
    p.comp_zero       = a;
    p.comp_one        = b;
    p.comp_two        = c;
    p.comp_three      = d;
    return p;
  endfunction

  // Mostly small noise around the scene, sometimes motion, sometimes rails
  function automatic logic [COMP_W-1:0] pick_sample(int slot, int c);
    int r;
    int amp;
    int v;
    r = $urandom_range(99);
    if (r < 70) begin
      amp = 1 << $urandom_range(12);
      v = int'(scene[slot][c]) + int'($urandom_range(2 * amp)) - amp;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
    end else if (r < 88) begin
      scene[slot][c] = COMP_W'($urandom);
      v = int'(scene[slot][c]);
    end else begin
      v = ($urandom_range(1) == 0) ? 0 : 65535;
    end
    return COMP_W'(v);
  endfunction

  function automatic trd_in_t make_pixel(bit sof, bit clr);
    int slot;
    int c;
    logic [COMP_W-1:0] s [NUM_COMP];
    if (sof) gen_pos = 0;
    slot = gen_pos % SCENE_SLOTS;
    for (c = 0; c < NUM_COMP; c++) s[c] = pick_sample(slot, c);
    gen_pos++;
    return px(sof, clr, s[0], s[1], s[2], s[3]);
  endfunction

  // Queue well-formed frames (mostly tiny) with a little noise in the framing
  task automatic queue_frames(int n_items);
    int queued;
    int len;
    int r;
    int i;
    queued = 0;
    while (queued < n_items) begin
      r = $urandom_range(99);
      if (r < 70)      len = $urandom_range(8, 1);
      else if (r < 95) len = $urandom_range(40, 9);
      else             len = $urandom_range(300, 100);
      for (i = 0; i < len; i++) begin
        // Occasionally drop the frame start or put a stray one mid-frame
        pending_pixels.push_back(make_pixel(
          (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(99) == 0),
          $urandom_range(19) == 0));
      end
      queued += len;
    end
  endtask

  // Wait until every pixel has been driven and every result has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || predicted_pixels.size() != 0);
    repeat (2 * PIPE_LATENCY) @(negedge clk);
  endtask

  // Write one register and update the shadow copy with it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_FRAMES:    avg_frames  = data[FRAMES_W-1:0];
      REG_THRESHOLD: motion_thr  = data[THR_W-1:0];
      REG_ENABLE:    lane_enable = data[NUM_COMP-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] d;
    int r;
    if ($urandom_range(3) != 0) begin
      d = CFG_DATA_W'($urandom);
      r = $urandom_range(6);
      case (r)
        0: d[FRAMES_W-1:0] = FRAMES_W'(1);
        1: d[FRAMES_W-1:0] = FRAMES_W'(MAX_FRAMES);
        2: d[FRAMES_W-1:0] = '0;
        3: d[FRAMES_W-1:0] = FRAMES_W'($urandom_range(511, MAX_FRAMES + 1));
        4: d[FRAMES_W-1:0] = FRAMES_W'($urandom_range(8, 2));
        default: d[FRAMES_W-1:0] = FRAMES_W'($urandom_range(MAX_FRAMES, 1));
      endcase
      write_reg(REG_FRAMES, d);
    end
    if ($urandom_range(3) != 0) begin
      r = $urandom_range(5);
      case (r)
        0: d = '0;
        1: d = 16'hffff;
        2: d = CFG_DATA_W'($urandom);
        default: d = CFG_DATA_W'($urandom_range(4000));
      endcase
      write_reg(REG_THRESHOLD, d);
    end
    if ($urandom_range(3) != 0) write_reg(REG_ENABLE, CFG_DATA_W'($urandom));
    if ($urandom_range(7) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase;
    int i;
    int c;
    avg_frames     = FRAMES_W'(FRAMES_RESET);
    motion_thr     = THR_W'(THR_RESET);
    lane_enable    = NUM_COMP'(MASK_RESET);
    pixel_pos      = 0;
    gen_pos        = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    gap_max        = 3;
    stall_max      = 3;
    for (i = 0; i < FRAME_PIXELS; i++) acc_mem[i] = '0;
    for (i = 0; i < SCENE_SLOTS; i++)
      for (c = 0; c < NUM_COMP; c++) scene[i][c] = COMP_W'($urandom);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero store, rails, cleared history, second position
    @(negedge clk);
    pending_pixels.push_back(px(1, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_pixels.push_back(px(1, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    pending_pixels.push_back(px(1, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    pending_pixels.push_back(px(1, 1, 16'h1000, 16'h1000, 16'h1000, 16'h1000));
    pending_pixels.push_back(px(1, 0, 16'h0000, 16'hffff, 16'h5555, 16'haaaa));
    pending_pixels.push_back(px(0, 0, 16'haaaa, 16'h5555, 16'hffff, 16'h0000));
    wait_idle();

    // Averaging over one frame follows the input even at zero threshold
    write_reg(REG_FRAMES, 16'd1);
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_ENABLE, 16'h0005);
    @(negedge clk);
    pending_pixels.push_back(px(1, 0, 16'h1234, 16'hffff, 16'h0000, 16'h8000));
    pending_pixels.push_back(px(1, 0, 16'h4321, 16'h0001, 16'hfffe, 16'h7fff));
    wait_idle();

    // Zero length acts as the longest; all lanes off; stray index ignored
    write_reg(REG_FRAMES, 16'hfe00);
    write_reg(REG_THRESHOLD, 16'hffff);
    write_reg(REG_ENABLE, 16'h0000);
    write_reg(REG_UNUSED, 16'hffff);
    @(negedge clk);
    pending_pixels.push_back(px(1, 0, 16'hbeef, 16'h0000, 16'hffff, 16'h8001));
    // Cleared history with lanes off writes zero back
    pending_pixels.push_back(px(1, 1, 16'h7777, 16'hffff, 16'h0001, 16'hc000));
    wait_idle();

    // Length above the limit, alternate lanes, threshold of one
    write_reg(REG_FRAMES, 16'hff2c);
    write_reg(REG_THRESHOLD, 16'd1);
    write_reg(REG_ENABLE, 16'hfffa);
    @(negedge clk);
    pending_pixels.push_back(px(1, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_pixels.push_back(px(1, 0, 16'h0002, 16'h0002, 16'hffff, 16'hffff));
    pending_pixels.push_back(px(1, 0, 16'h0003, 16'h0003, 16'hfff0, 16'hfff0));
    pending_pixels.push_back(px(0, 1, 16'hffff, 16'h8000, 16'h0000, 16'h0001));
    wait_idle();

    // Random phases; each one drains fully before the settings move
    for (phase = 0; phase < 10; phase++) begin
      random_config();
      case ($urandom_range(3))
        0:       begin gap_max = 0; stall_max = 0; end
        1:       begin gap_max = 8; stall_max = 2; end
        2:       begin gap_max = 0; stall_max = 8; end
        default: begin gap_max = 4; stall_max = 4; end
      endcase
      @(negedge clk);
      queue_frames(100);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/trd_pkg.sv
hw/rtl/trd_ram.sv
hw/rtl/trd_wdiv.sv
hw/rtl/trd_lane.sv
hw/rtl/temporal_recursive_denoise.sv
dv/testbench.sv
